FILE: hw/rtl/pfb_pkg.sv
// Shared constants and types for the polyphase FIR branch bank.
`default_nettype none
package pfb_pkg;

  // Default configuration of the bank
  localparam int TAPS_DEF       = 16;
  localparam int BRANCHES_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF  = 40;
  localparam int OUT_WIDTH_DEF  = 14;

  // Fixed port widths
  localparam int BRANCH_W   = 4;
  localparam int TAP_IDX_W  = 4;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_IN_W  = 16;
  localparam int FILTERED_W = 14;

  // Command queue depth between front and engine
  localparam int QUEUE_DEPTH = 2;

  // Opcode field codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  typedef enum logic {
    CMD_LOAD,
    CMD_FILTER
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_RUN,
    ENG_DRAIN,
    ENG_DONE
  } eng_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pfb_cmd_queue.sv
// Small register FIFO that carries commands from the front to the engine.
`default_nettype none
module pfb_cmd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pfb_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/pfb_front.sv
// Front end: accepts input transactions, drops out-of-range ones, queues commands.
`default_nettype none
module pfb_front #(
  parameter int TAPS       = pfb_pkg::TAPS_DEF,
  parameter int BRANCHES   = pfb_pkg::BRANCHES_DEF,
  parameter int DATA_WIDTH = pfb_pkg::DATA_WIDTH_DEF,
  parameter int COEF_WIDTH = pfb_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_opcode,
  input  wire logic [pfb_pkg::BRANCH_W-1:0]        in_branch,
  input  wire logic                                in_rail,
  input  wire logic [pfb_pkg::TAP_IDX_W-1:0]       in_tap_index,
  input  wire logic signed [pfb_pkg::COEF_IN_W-1:0] in_coef_value,
  input  wire logic signed [pfb_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                     cmd_valid,
  input  wire logic                                cmd_pop,
  output pfb_pkg::cmd_kind_t                       cmd_kind,
  output logic [pfb_pkg::BRANCH_W-1:0]             cmd_branch,
  output logic                                     cmd_rail,
  output logic [$clog2(TAPS)-1:0]                  cmd_tap,
  output logic signed [COEF_WIDTH-1:0]             cmd_coef,
  output logic signed [DATA_WIDTH-1:0]             cmd_sample
);

  localparam int TW  = $clog2(TAPS);
  localparam int QW  = 1 + pfb_pkg::BRANCH_W + 1 + TW + COEF_WIDTH + DATA_WIDTH;
  localparam int SXW = (DATA_WIDTH > pfb_pkg::SAMPLE_W) ? DATA_WIDTH : pfb_pkg::SAMPLE_W;
  localparam int CXW = (COEF_WIDTH > pfb_pkg::COEF_IN_W) ? COEF_WIDTH : pfb_pkg::COEF_IN_W;

  logic                   accept, push, full, is_filter, branch_ok, tap_ok;
  logic signed [SXW-1:0]  smp_ext;
  logic signed [CXW-1:0]  coef_ext;
  logic [QW-1:0]          push_data, pop_data;
  logic                   kind_bit;

  assign in_stall  = full;
  assign accept    = in_valid && !in_stall;
  assign is_filter = (in_opcode == pfb_pkg::OP_FILTER);
  assign branch_ok = (int'(in_branch) < BRANCHES);
  assign tap_ok    = (int'(in_tap_index) < TAPS);
  assign push      = accept && branch_ok && (is_filter || tap_ok);

  // sign-extend from 16 bits, then wrap to the internal widths
  assign smp_ext  = SXW'(in_sample);
  assign coef_ext = CXW'(in_coef_value);

  assign push_data = {is_filter, in_branch, in_rail, TW'(in_tap_index),
                      coef_ext[COEF_WIDTH-1:0], smp_ext[DATA_WIDTH-1:0]};

  pfb_cmd_queue #(
    .WIDTH (QW),
    .DEPTH (pfb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (pop_data),
    .not_empty (cmd_valid)
  );

  assign {kind_bit, cmd_branch, cmd_rail, cmd_tap, cmd_coef, cmd_sample} = pop_data;
  assign cmd_kind = kind_bit ? pfb_pkg::CMD_FILTER : pfb_pkg::CMD_LOAD;

endmodule
`default_nettype wire

FILE: hw/rtl/pfb_engine.sv
// Back end: coefficient and delay memories, one shared MAC, result register.
`default_nettype none
module pfb_engine #(
  parameter int TAPS       = pfb_pkg::TAPS_DEF,
  parameter int BRANCHES   = pfb_pkg::BRANCHES_DEF,
  parameter int DATA_WIDTH = pfb_pkg::DATA_WIDTH_DEF,
  parameter int COEF_WIDTH = pfb_pkg::COEF_WIDTH_DEF,
  parameter int ACC_WIDTH  = pfb_pkg::ACC_WIDTH_DEF,
  parameter int OUT_WIDTH  = pfb_pkg::OUT_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_pop,
  input  wire pfb_pkg::cmd_kind_t              cmd_kind,
  input  wire logic [pfb_pkg::BRANCH_W-1:0]    cmd_branch,
  input  wire logic                            cmd_rail,
  input  wire logic [$clog2(TAPS)-1:0]         cmd_tap,
  input  wire logic signed [COEF_WIDTH-1:0]    cmd_coef,
  input  wire logic signed [DATA_WIDTH-1:0]    cmd_sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [pfb_pkg::FILTERED_W-1:0] out_filtered,
  output logic [pfb_pkg::BRANCH_W-1:0]         out_branch_out,
  output logic                                 out_rail_out
);

  localparam int FILTERS   = 2 * BRANCHES;
  localparam int FW        = $clog2(FILTERS);
  localparam int TW        = $clog2(TAPS);
  localparam int MEM_DEPTH = FILTERS * TAPS;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int PW        = DATA_WIDTH + COEF_WIDTH;
  localparam int EXT_W     = (PW > ACC_WIDTH) ? PW : ACC_WIDTH;
  localparam int SH        = (ACC_WIDTH > OUT_WIDTH) ? (ACC_WIDTH - OUT_WIDTH) : 0;

  pfb_pkg::eng_state_t state_r, state_nxt;

  logic signed [COEF_WIDTH-1:0] coef_mem [MEM_DEPTH];
  logic signed [DATA_WIDTH-1:0] delay_mem [MEM_DEPTH];

  logic [FILTERS-1:0]           row_vld_r;
  logic [FW-1:0]                cmd_filt, filt_r;
  logic [AW-1:0]                cmd_base, base_r, rd_addr, p1_addr_r;
  logic [TW-1:0]                rd_cnt_r;
  logic                         p1_vld_r, p1_last_r, p2_vld_r, p2_last_r;
  logic                         row_on_r;
  logic signed [DATA_WIDTH-1:0] carry_r, dly_q_r;
  logic signed [COEF_WIDTH-1:0] cf_q_r;
  logic signed [PW-1:0]         prod_r;
  logic signed [EXT_W-1:0]      prod_ext;
  logic signed [ACC_WIDTH-1:0]  acc_r, acc_shift;
  logic [pfb_pkg::BRANCH_W-1:0] branch_r;
  logic                         rail_r;
  logic                         issue, start, coef_we, finish, last_issue;
  logic                         out_valid_r;
  logic signed [pfb_pkg::FILTERED_W-1:0] out_filtered_r;
  logic [pfb_pkg::BRANCH_W-1:0] out_branch_r;
  logic                         out_rail_r;

  assign cmd_filt   = FW'({cmd_branch, cmd_rail});
  assign cmd_base   = AW'(AW'(cmd_filt) * AW'(TAPS));
  assign rd_addr    = base_r + AW'(rd_cnt_r);
  assign last_issue = (rd_cnt_r == TW'(TAPS - 1));

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    issue     = 1'b0;
    start     = 1'b0;
    coef_we   = 1'b0;
    finish    = 1'b0;
    case (state_r)
      pfb_pkg::ENG_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd_kind == pfb_pkg::CMD_LOAD) begin
            coef_we = 1'b1;
          end else begin
            start     = 1'b1;
            state_nxt = pfb_pkg::ENG_RUN;
          end
        end
      end
      pfb_pkg::ENG_RUN: begin
        issue = 1'b1;
        if (last_issue) begin
          state_nxt = pfb_pkg::ENG_DRAIN;
        end
      end
      pfb_pkg::ENG_DRAIN: begin
        if (p2_last_r) begin
          state_nxt = pfb_pkg::ENG_DONE;
        end
      end
      pfb_pkg::ENG_DONE: begin
        if (!out_valid_r || !out_stall) begin
          finish    = 1'b1;
          state_nxt = pfb_pkg::ENG_IDLE;
        end
      end
      default: state_nxt = pfb_pkg::ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfb_pkg::ENG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control pipeline and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r    <= 1'b0;
      p1_last_r   <= 1'b0;
      p2_vld_r    <= 1'b0;
      p2_last_r   <= 1'b0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
      rd_cnt_r    <= '0;
    end else begin
      p1_vld_r  <= issue;
      p1_last_r <= issue && last_issue;
      p2_vld_r  <= p1_vld_r;
      p2_last_r <= p1_last_r;
      if (start) begin
        rd_cnt_r <= '0;
      end else if (issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (finish) begin
        row_vld_r[filt_r] <= 1'b1;
        out_valid_r       <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memories, read data registered
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[cmd_base + AW'(cmd_tap)] <= cmd_coef;
    end
    cf_q_r <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (p1_vld_r) begin
      delay_mem[p1_addr_r] <= carry_r;
    end
    dly_q_r <= delay_mem[rd_addr];
  end

  // shift-through: tap k gets the carried value, old tap k moves on
  assign prod_ext = EXT_W'(prod_r);

  always_ff @(posedge clk) begin
    if (start) begin
      filt_r   <= cmd_filt;
      base_r   <= cmd_base;
      branch_r <= cmd_branch;
      rail_r   <= cmd_rail;
      row_on_r <= row_vld_r[cmd_filt];
      carry_r  <= cmd_sample;
    end else if (p1_vld_r) begin
      carry_r <= row_on_r ? dly_q_r : '0;
    end
    if (issue) begin
      p1_addr_r <= rd_addr;
    end
    if (p1_vld_r) begin
      prod_r <= carry_r * cf_q_r;
    end
    if (start) begin
      acc_r <= '0;
    end else if (p2_vld_r) begin
      acc_r <= acc_r + prod_ext[ACC_WIDTH-1:0];
    end
  end

  assign acc_shift = acc_r >>> SH;

  always_ff @(posedge clk) begin
    if (finish) begin
      out_filtered_r <= acc_shift[pfb_pkg::FILTERED_W-1:0];
      out_branch_r   <= branch_r;
      out_rail_r     <= rail_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_filtered   = out_filtered_r;
  assign out_branch_out = out_branch_r;
  assign out_rail_out   = out_rail_r;

endmodule
`default_nettype wire

FILE: hw/rtl/polyphase_fir_branch_bank.sv
// Filter transactions share one MAC over one memory port, so the engine finishes one before it starts the next.
// Coefficient loads retire at one per cycle while the engine is idle; two commands can wait in the queue.
// Reset: synchronous, active low; control cleared, delay lines read as zero via
// per-filter row flags (no clearing pass). Coefficients are undefined until loaded.
`default_nettype none
module polyphase_fir_branch_bank #(
  parameter int TAPS       = pfb_pkg::TAPS_DEF,
  parameter int BRANCHES   = pfb_pkg::BRANCHES_DEF,
  parameter int DATA_WIDTH = pfb_pkg::DATA_WIDTH_DEF,
  parameter int COEF_WIDTH = pfb_pkg::COEF_WIDTH_DEF,
  parameter int ACC_WIDTH  = pfb_pkg::ACC_WIDTH_DEF,
  parameter int OUT_WIDTH  = pfb_pkg::OUT_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_opcode,
  input  wire logic [pfb_pkg::BRANCH_W-1:0]         in_branch,
  input  wire logic                                 in_rail,
  input  wire logic [pfb_pkg::TAP_IDX_W-1:0]        in_tap_index,
  input  wire logic signed [pfb_pkg::COEF_IN_W-1:0] in_coef_value,
  input  wire logic signed [pfb_pkg::SAMPLE_W-1:0]  in_sample,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [pfb_pkg::FILTERED_W-1:0]     out_filtered,
  output logic [pfb_pkg::BRANCH_W-1:0]              out_branch_out,
  output logic                                      out_rail_out
);

  // Command path between the front (classify + queue) and the engine
  logic                         cmd_valid;
  logic                         cmd_pop;
  pfb_pkg::cmd_kind_t           cmd_kind;
  logic [pfb_pkg::BRANCH_W-1:0] cmd_branch;
  logic                         cmd_rail;
  logic [$clog2(TAPS)-1:0]      cmd_tap;
  logic signed [COEF_WIDTH-1:0] cmd_coef;
  logic signed [DATA_WIDTH-1:0] cmd_sample;

  // Front: takes every transaction it has room for. Out-of-range branches
  // and out-of-range taps on loads are dropped here and never reach the engine.
  pfb_front #(
    .TAPS       (TAPS),
    .BRANCHES   (BRANCHES),
    .DATA_WIDTH (DATA_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_branch     (in_branch),
    .in_rail       (in_rail),
    .in_tap_index  (in_tap_index),
    .in_coef_value (in_coef_value),
    .in_sample     (in_sample),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop),
    .cmd_kind      (cmd_kind),
    .cmd_branch    (cmd_branch),
    .cmd_rail      (cmd_rail),
    .cmd_tap       (cmd_tap),
    .cmd_coef      (cmd_coef),
    .cmd_sample    (cmd_sample)
  );

  // Engine: a load writes one coefficient memory entry. A filter command
  // walks the filter's TAPS entries: each cycle reads one delay/coef pair,
  // writes back the shifted-in value, multiplies, then accumulates at
  // ACC_WIDTH bits. The result sits in an output register so the engine
  // can pick up the next command while it waits to be taken.
  pfb_engine #(
    .TAPS       (TAPS),
    .BRANCHES   (BRANCHES),
    .DATA_WIDTH (DATA_WIDTH),
    .COEF_WIDTH (COEF_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH),
    .OUT_WIDTH  (OUT_WIDTH)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop),
    .cmd_kind       (cmd_kind),
    .cmd_branch     (cmd_branch),
    .cmd_rail       (cmd_rail),
    .cmd_tap        (cmd_tap),
    .cmd_coef       (cmd_coef),
    .cmd_sample     (cmd_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_filtered   (out_filtered),
    .out_branch_out (out_branch_out),
    .out_rail_out   (out_rail_out)
  );

endmodule
`default_nettype wire

FILE: verif/polyphase_fir_branch_bank_tb.sv
// Self-checking testbench for the polyphase FIR branch bank: loads and filter transactions.
module polyphase_fir_branch_bank_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Bank geometry follows the package defaults, same as the instance below
  localparam int TAPS       = pfb_pkg::TAPS_DEF;
  localparam int BRANCHES   = pfb_pkg::BRANCHES_DEF;
  localparam int DATA_WIDTH = pfb_pkg::DATA_WIDTH_DEF;
  localparam int COEF_WIDTH = pfb_pkg::COEF_WIDTH_DEF;
  localparam int ACC_WIDTH  = pfb_pkg::ACC_WIDTH_DEF;
  localparam int OUT_WIDTH  = pfb_pkg::OUT_WIDTH_DEF;
  localparam int FILTERS    = BRANCHES * 2;
  localparam int ACC_SHIFT  = (ACC_WIDTH > OUT_WIDTH) ? ACC_WIDTH - OUT_WIDTH : 0;

  // Port widths
  localparam int BRANCH_W   = pfb_pkg::BRANCH_W;
  localparam int TAP_IDX_W  = pfb_pkg::TAP_IDX_W;
  localparam int COEF_IN_W  = pfb_pkg::COEF_IN_W;
  localparam int SAMPLE_W   = pfb_pkg::SAMPLE_W;
  localparam int FILTERED_W = pfb_pkg::FILTERED_W;

  // Stimulus volume and back-pressure plan
  localparam int ITEMS       = 950;
  localparam int HOLD_AT     = 480;   // transactions accepted before the long result hold
  localparam int HOLD_CYCLES = 400;
  // Idle limit: the longest quiet stretches of a correct run come from a filter transaction,
  // the long hold and runs of random stalls at 53%.
  // Ten times the worst of those covers every correct run.
  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    logic                        op;
    logic [BRANCH_W-1:0]         br;
    logic                        rl;
    logic [TAP_IDX_W-1:0]        tap;
    logic signed [COEF_IN_W-1:0] coef;
    logic signed [SAMPLE_W-1:0]  smp;
  } bank_cmd_t;

  typedef struct {
    logic signed [FILTERED_W-1:0] filt;
    logic [BRANCH_W-1:0]          br;
    logic                         rl;
  } fir_out_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  // DUT inputs, all known from time zero
  logic                        in_valid      = 1'b0;
  logic                        in_opcode     = pfb_pkg::OP_LOAD;
  logic [BRANCH_W-1:0]         in_branch     = '0;
  logic                        in_rail       = 1'b0;
  logic [TAP_IDX_W-1:0]        in_tap_index  = '0;
  logic signed [COEF_IN_W-1:0] in_coef_value = '0;
  logic signed [SAMPLE_W-1:0]  in_sample     = '0;
  logic                        out_stall     = 1'b0;

  // DUT outputs
  logic                         in_stall;
  logic                         out_valid;
  logic signed [FILTERED_W-1:0] out_filtered;
  logic [BRANCH_W-1:0]          out_branch_out;
  logic                         out_rail_out;

  polyphase_fir_branch_bank u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_branch      (in_branch),
    .in_rail        (in_rail),
    .in_tap_index   (in_tap_index),
    .in_coef_value  (in_coef_value),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_filtered   (out_filtered),
    .out_branch_out (out_branch_out),
    .out_rail_out   (out_rail_out)
  );

  // Commands waiting to be driven, and filter outputs waiting to come back
  bank_cmd_t pending_cmds[$];
  fir_out_t  fir_out_q[$];
  bank_cmd_t cur_cmd;

  // Shadow of the bank: delay lines start at zero, coefficients are only
  // ever read after the stimulus has written them
  logic signed [DATA_WIDTH-1:0] delay_line [FILTERS][TAPS];
  logic signed [COEF_WIDTH-1:0] coef_bank  [FILTERS][TAPS];

  // Which coefficients the generator has already loaded, per filter
  bit [TAPS-1:0] gen_loaded [FILTERS];

  int total_cmds   = 0;
  int sent_cnt     = 0;
  int err_cnt      = 0;
  int hold_left    = 0;
  bit hold_used    = 1'b0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Shadow bank update for one accepted transaction. A filter transaction
  // shifts the new sample in at tap 0, sums delay*coef over all taps, wraps
  // to ACC_WIDTH and keeps the top OUT_WIDTH bits by arithmetic shift.
  // ---------------------------------------------------------------------------
  task automatic fir_bank_step(input bank_cmd_t c);
    int                          f;
    int                          i;
    longint                      acc;
    longint                      d;
    longint                      k;
    logic signed [ACC_WIDTH-1:0] acc_w;
    logic signed [ACC_WIDTH-1:0] shifted;
    fir_out_t                    r;
    if (c.br >= BRANCHES) return;   // out-of-range branch: ignored
    f = c.br * 2 + c.rl;
    if (c.op == pfb_pkg::OP_LOAD) begin
      if (c.tap < TAPS) coef_bank[f][c.tap] = c.coef;
      return;
    end
    for (i = TAPS - 1; i > 0; i--) delay_line[f][i] = delay_line[f][i-1];
    delay_line[f][0] = c.smp;
    acc = 0;
    for (i = 0; i < TAPS; i++) begin
      d = longint'(delay_line[f][i]);
      k = longint'(coef_bank[f][i]);
      acc += d * k;
    end
    acc_w   = acc[ACC_WIDTH-1:0];
    shifted = acc_w >>> ACC_SHIFT;
    r.filt  = shifted[FILTERED_W-1:0];
    r.br    = c.br;
    r.rl    = c.rl;
    fir_out_q.push_back(r);
  endtask

  // Stimulus builders; the unused payload fields carry random junk
  task automatic push_load(input int br, input int rl, input int tap, input int coef);
    bank_cmd_t c;
    c.op   = pfb_pkg::OP_LOAD;
    c.br   = BRANCH_W'(br);
    c.rl   = 1'(rl);
    c.tap  = TAP_IDX_W'(tap);
    c.coef = COEF_IN_W'(coef);
    c.smp  = SAMPLE_W'($urandom_range(0, 16'hFFFF));
    pending_cmds.push_back(c);
    gen_loaded[br*2 + rl][tap] = 1'b1;
  endtask

  task automatic push_filter(input int br, input int rl, input int smp);
    bank_cmd_t c;
    c.op   = pfb_pkg::OP_FILTER;
    c.br   = BRANCH_W'(br);
    c.rl   = 1'(rl);
    c.tap  = TAP_IDX_W'($urandom_range(0, TAPS - 1));
    c.coef = COEF_IN_W'($urandom_range(0, 16'hFFFF));
    c.smp  = SAMPLE_W'(smp);
    pending_cmds.push_back(c);
  endtask

  // Idle percentage per side: the sender idles 35 / receiver 53 in the first
  // third, swapped in the second third, no random idling in the last third.
  function automatic int idle_pct(input bit for_sender);
    if (sent_cnt < total_cmds / 3) return for_sender ? 35 : 53;
    if (sent_cnt < 2 * total_cmds / 3) return for_sender ? 53 : 35;
    return 0;
  endfunction

  task automatic log_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the next command when the channel is free. The shadow
  // bank sees a transaction at the edge where valid is high and stall low.
  // While the receiver is in its long hold the sender never idles, so the
  // command queue inside the bank fills and in_stall rises.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        fir_bank_step(cur_cmd);
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 &&
            (hold_left != 0 || $urandom_range(0, 99) >= idle_pct(1'b1))) begin
          cur_cmd       = pending_cmds.pop_front();
          in_valid      <= 1'b1;
          in_opcode     <= cur_cmd.op;
          in_branch     <= cur_cmd.br;
          in_rail       <= cur_cmd.rl;
          in_tap_index  <= cur_cmd.tap;
          in_coef_value <= cur_cmd.coef;
          in_sample     <= cur_cmd.smp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result-side stall: one long hold once, random stalls otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_used && sent_cnt >= HOLD_AT) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
    end
  end

  // Monitor: each result transaction against the oldest expected output
  always @(posedge clk) begin : mon
    fir_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (fir_out_q.size() == 0) begin
        log_error($sformatf("unexpected result filtered=%0d branch=%0d rail=%0d",
                            out_filtered, out_branch_out, out_rail_out));
      end else begin
        want = fir_out_q.pop_front();
        if (out_filtered !== want.filt)
          log_error($sformatf("filtered exp %0d got %0d (branch %0d rail %0d)",
                              want.filt, out_filtered, want.br, want.rl));
        if (out_branch_out !== want.br)
          log_error($sformatf("branch_out exp %0d got %0d", want.br, out_branch_out));
        if (out_rail_out !== want.rl)
          log_error($sformatf("rail_out exp %0d got %0d", want.rl, out_rail_out));
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------
  initial begin : stim
    int dir_coef [16];
    int dir_smp  [8];
    int f;
    int t;
    int br;
    int rl;
    int pick;
    int smp;

    dir_coef = '{32767, -32768, -1, 0, 1, 21845, -21846, 32767,
                 -32768, 256, -256, 12345, -12345, 32767, -32768, 7};
    dir_smp  = '{32767, -32768, -32768, -32768, 0, -1, 21845, -21846};

    for (f = 0; f < FILTERS; f++) begin
      gen_loaded[f] = '0;
      for (t = 0; t < TAPS; t++) begin
        delay_line[f][t] = '0;
        coef_bank[f][t]  = '0;
      end
    end

    // Directed: full coefficient set of branch 0 in-phase with extreme values,
    // then extreme samples, including a run of most-negative samples so the
    // largest products meet the largest coefficients
    for (t = 0; t < TAPS; t++) push_load(0, 0, t, dir_coef[t]);
    for (t = 0; t < 8; t++) push_filter(0, 0, dir_smp[t]);

    // Random: mostly complete sequences (missing coefficients first, then a
    // sample), mixed with stray coefficient rewrites on any filter
    while (pending_cmds.size() < ITEMS) begin
      br = $urandom_range(0, BRANCHES - 1);
      rl = $urandom_range(0, 1);
      if ($urandom_range(0, 99) < 35) begin
        push_load(br, rl, $urandom_range(0, TAPS - 1), $urandom_range(0, 16'hFFFF));
      end else begin
        for (t = 0; t < TAPS; t++)
          if (!gen_loaded[br*2 + rl][t])
            push_load(br, rl, t, $urandom_range(0, 16'hFFFF));
        pick = $urandom_range(0, 9);
        if (pick == 0)      smp = 32767;
        else if (pick == 1) smp = -32768;
        else                smp = $urandom_range(0, 16'hFFFF);
        push_filter(br, rl, smp);
      end
    end
    total_cmds = pending_cmds.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_cnt != total_cmds) @(posedge clk);
    while (fir_out_q.size() != 0) @(posedge clk);
    // let any stray result surface
    repeat (TAPS + 8) @(posedge clk);

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
